[rtl/pse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 5;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DIV_STEPS       = DATA_W;

    // token codes
    typedef enum logic [CMD_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_SWAP = 3'd5,
        OP_FIN  = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_TOOMANY  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] number;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    push;
        logic    rd_issue;
        logic    alu_exec;
        logic    div_start;
        logic    div_capture;
        logic    wb;
        logic    swap1;
        logic    swap2;
        logic    finish;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic empty;
        logic one;
        logic full;
        logic lt2;
        logic top_zero;
        logic div_busy;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/pse_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module pse_div
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [DATA_W-1:0]      o_quotient
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    logic [SW-1:0]     r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;

    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    // take magnitudes of the signed operands
    assign w_mag_a = i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
    assign w_mag_b = i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;

    // one restoring step: shift in next dividend bit, try subtract
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= SW'(DIV_STEPS);
        end else if (r_step != '0) begin
            r_step <= r_step - SW'(1);
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_step != '0) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_step != '0);
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("divider not busy after start");

endmodule

`default_nettype wire

[rtl/pse_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module pse_dpath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in      i_in_data,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out          o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    logic [CW-1:0]       r_cnt;
    t_op                 r_op;
    logic [DATA_W-1:0]   r_num;
    logic [DATA_W-1:0]   r_top;
    logic [DATA_W-1:0]   r_bot;
    logic [DATA_W-1:0]   r_rd;
    logic [DATA_W-1:0]   r_res;
    logic [DATA_W-1:0]   r_fin;
    t_status             r_status;
    logic                r_ov;
    t_out                r_out;

    logic [CW-1:0]       w_cnt_m1;
    logic [CW-1:0]       w_cnt_m2;
    logic                w_empty;
    logic                w_full;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [DATA_W-1:0]   w_wr_data;
    logic [DATA_W-1:0]   w_prod;
    logic [DATA_W-1:0]   w_top_or_zero;
    logic [CW+DEPTH_W-1:0] w_cnt_ext;
    logic                w_div_busy;
    logic [DATA_W-1:0]   w_div_q;

    assign w_cnt_m1 = r_cnt - CW'(1);
    assign w_cnt_m2 = r_cnt - CW'(2);
    assign w_empty  = (r_cnt == '0);
    assign w_full   = (r_cnt == CW'(STACK_DEPTH));
    assign w_prod   = r_rd * r_top;
    assign w_top_or_zero = w_empty ? '0 : r_top;
    assign w_cnt_ext = {{DEPTH_W{1'b0}}, r_cnt};

    // status toward the controller
    assign o_stat.op       = r_op;
    assign o_stat.empty    = w_empty;
    assign o_stat.one      = (r_cnt == CW'(1));
    assign o_stat.full     = w_full;
    assign o_stat.lt2      = (r_cnt < CW'(2));
    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_busy = r_ov && !i_out_ready;

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    // select the single stack write of this cycle
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt[AW-1:0];
        w_wr_data = r_num;
        if (i_cmd.push) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.swap1) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_cnt_m1[AW-1:0];
            w_wr_data = r_bot;
        end else if (i_cmd.swap2) begin
            w_wr_en   = 1'b1;
            w_wr_addr = '0;
            w_wr_data = r_bot;
        end else if (i_cmd.wb) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_cnt_m2[AW-1:0];
            w_wr_data = r_res;
        end
    end

    // stack memory: one write, one registered read of the second entry
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd <= r_mem[w_cnt_m2[AW-1:0]];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.wb) begin
            r_cnt <= w_cnt_m1;
        end else if (i_cmd.finish) begin
            r_cnt <= '0;
        end
    end

    // hold the token
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= t_op'(i_in_data.cmd);
            r_num <= i_in_data.number;
        end
    end

    // top and bottom copies of the stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= r_num;
            if (w_empty) begin
                r_bot <= r_num;
            end
        end else if (i_cmd.swap1) begin
            r_top <= r_bot;
            r_bot <= r_top;
        end else if (i_cmd.wb) begin
            r_top <= r_res;
            if (r_cnt == CW'(2)) begin
                r_bot <= r_res;
            end
        end
    end

    // arithmetic result
    always_ff @(posedge i_clk) begin
        if (i_cmd.alu_exec) begin
            case (r_op)
                OP_ADD:  r_res <= r_rd + r_top;
                OP_SUB:  r_res <= r_rd - r_top;
                OP_MUL:  r_res <= w_prod;
                default: r_res <= r_res;
            endcase
        end else if (i_cmd.div_capture) begin
            r_res <= w_div_q;
        end
    end

    // finish value and status
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fin <= w_top_or_zero;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status    <= r_status;
            r_out.top_value <= (r_op == OP_FIN) ? r_fin : w_top_or_zero;
            r_out.depth     <= w_cnt_ext[DEPTH_W-1:0];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !w_full)
        else $error("push into full stack");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_ov && !i_out_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[rtl/pse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl
    import pse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_WB     = 7'b0010000,
        S_SWAP2  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // sequence one token
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_DONE;
                unique case (i_stat.op) inside
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (i_stat.lt2) begin
                            o_cmd.status = ST_UNDERFLOW;
                        end else if ((i_stat.op == OP_DIV) && i_stat.top_zero) begin
                            o_cmd.status = ST_DIVZERO;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_EXEC;
                        end
                    end
                    OP_SWAP: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_UNDERFLOW;
                        end else begin
                            o_cmd.swap1 = 1'b1;
                            n_state     = S_SWAP2;
                        end
                    end
                    OP_FIN: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else if (!i_stat.one) begin
                            o_cmd.status = ST_TOOMANY;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_OK;
                    end
                endcase
            end
            S_EXEC: begin
                if (i_stat.op == OP_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.alu_exec = 1'b1;
                    n_state        = S_WB;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_capture = 1'b1;
                    n_state           = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_DONE;
            end
            S_SWAP2: begin
                o_cmd.swap2 = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_stat.div_busy |=> (r_state == S_DIV))
        else $error("left divide wait while divider busy");

    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (i_stat.op == OP_DIV) && !i_stat.top_zero)
        else $error("divider started on non-divide or zero divisor");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch_in |=> (r_state == S_DECODE))
        else $error("accepted token not decoded");

endmodule

`default_nettype wire

[rtl/postfix_stack_evaluator_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Postfix stack evaluator: takes parsed RPN tokens (push, add, subtract,
// multiply, divide, swap bottom/top, finish) on a valid/ready input channel
// and returns one result per token (status, top of stack, depth) on a
// valid/ready output channel. The operand stack holds STACK_DEPTH signed
// 32-bit entries in a single-port-write memory; the top and bottom entries
// are mirrored in registers so each token needs at most one memory read.
// Tokens are handled one at a time. After the transfer a token is decoded;
// push, finish, error cases and code 7 then go straight to the result,
// add/subtract/multiply pass through execute and write-back, swap does a
// second write, and divide runs the bit-serial restoring divider (one
// quotient bit per cycle), then writes back. The result turns valid at the
// end of the last step and the next token can transfer in the cycle after.
// A waiting result sits in the output register; the next token is taken
// while it waits and stalls in its last cycle until the register frees.
module postfix_stack_evaluator_top
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pse_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
